// ===== rtl/core/gsd_pkg.sv =====
// Shared types, constants and distance tables of the gap safe distance calculator.
package gsd_pkg;

  localparam int SPD_W      = 14;
  localparam int ACC_W      = 13;
  localparam int OUT_W      = 17;
  localparam int REL_W      = 19;
  localparam int DIV_NW     = 30;
  localparam int DIV_DW     = 14;
  localparam int DIV_QW     = 18;
  localparam int DIV_STAGES = 6;
  localparam int DIV_STEPS  = DIV_QW / DIV_STAGES;
  localparam int DIST_W     = 13;

  localparam logic [18:0] BP_1 = 19'd51200;
  localparam logic [18:0] BP_2 = 19'd102400;
  localparam logic [18:0] BP_3 = 19'd153600;

  // ceil(2^28 / 200); exact floor division for dividends below about 1.8 million.
  localparam logic [20:0] RECIP_200 = 21'd1342178;
  localparam int          RECIP_SH  = 28;
  localparam logic [19:0] ROUND_200 = 20'd100;

  localparam logic [OUT_W-1:0] OUT_MAX = 17'd131071;

  localparam logic [4:0] MIN_TAB [2][3] = '{'{5'd3, 5'd8, 5'd20}, '{5'd6, 5'd12, 5'd30}};
  localparam logic [4:0] BUF_TAB [2][3] = '{'{5'd1, 5'd3, 5'd10}, '{5'd3, 5'd6, 5'd20}};

  typedef enum logic [1:0] {
    SEG_LOW,
    SEG_MID0,
    SEG_MID1,
    SEG_HIGH
  } seg_t;

  // Per-item data that rides alongside the divider.
  typedef struct packed {
    logic                    ratio;
    logic                    neg;
    logic                    front;
    logic                    heavy;
    logic [SPD_W-1:0]        ve;
    logic signed [REL_W-1:0] rel4;
  } side_t;

endpackage

// ===== rtl/core/gsd_div.sv =====
// Pipelined restoring divider, three quotient bits per stage, with side data.
module gsd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [gsd_pkg::DIV_NW-1:0]   dividend,
  input  logic [gsd_pkg::DIV_DW-1:0]   divisor,
  input  gsd_pkg::side_t               side_in,
  output logic                         out_vld,
  output logic [gsd_pkg::DIV_QW-1:0]   quot,
  output logic                         rem_nz,
  output gsd_pkg::side_t               side_out
);

  logic [gsd_pkg::DIV_DW-1:0] rem     [gsd_pkg::DIV_STAGES];
  logic [gsd_pkg::DIV_QW-1:0] sh      [gsd_pkg::DIV_STAGES];
  logic [gsd_pkg::DIV_QW-1:0] quo     [gsd_pkg::DIV_STAGES];
  logic [gsd_pkg::DIV_DW-1:0] dsr     [gsd_pkg::DIV_STAGES];
  gsd_pkg::side_t             side    [gsd_pkg::DIV_STAGES];
  logic                       vld     [gsd_pkg::DIV_STAGES];

  logic [gsd_pkg::DIV_DW-1:0] rem_next [gsd_pkg::DIV_STAGES];
  logic [gsd_pkg::DIV_QW-1:0] sh_next  [gsd_pkg::DIV_STAGES];
  logic [gsd_pkg::DIV_QW-1:0] quo_next [gsd_pkg::DIV_STAGES];

  always_comb begin
    logic [gsd_pkg::DIV_DW-1:0] r;
    logic [gsd_pkg::DIV_QW-1:0] s;
    logic [gsd_pkg::DIV_QW-1:0] q;
    logic [gsd_pkg::DIV_DW-1:0] d;
    logic [gsd_pkg::DIV_DW:0]   t;
    for (int k = 0; k < gsd_pkg::DIV_STAGES; k++) begin
      if (k == 0) begin
        // The quotient fits DIV_QW bits, so the top dividend bits are already below the divisor.
        r = {{(gsd_pkg::DIV_DW + gsd_pkg::DIV_QW - gsd_pkg::DIV_NW){1'b0}},
             dividend[gsd_pkg::DIV_NW-1:gsd_pkg::DIV_QW]};
        s = dividend[gsd_pkg::DIV_QW-1:0];
        q = '0;
        d = divisor;
      end else begin
        r = rem[k-1];
        s = sh[k-1];
        q = quo[k-1];
        d = dsr[k-1];
      end
      for (int j = 0; j < gsd_pkg::DIV_STEPS; j++) begin
        t = {r, s[gsd_pkg::DIV_QW-1]};
        s = {s[gsd_pkg::DIV_QW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t = t - {1'b0, d};
          q = {q[gsd_pkg::DIV_QW-2:0], 1'b1};
        end else begin
          q = {q[gsd_pkg::DIV_QW-2:0], 1'b0};
        end
        r = t[gsd_pkg::DIV_DW-1:0];
      end
      rem_next[k] = r;
      sh_next[k]  = s;
      quo_next[k] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < gsd_pkg::DIV_STAGES; k++) begin
        rem[k] <= rem_next[k];
        sh[k]  <= sh_next[k];
        quo[k] <= quo_next[k];
        dsr[k]  <= (k == 0) ? divisor : dsr[(k == 0) ? 0 : k-1];
        side[k] <= (k == 0) ? side_in : side[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < gsd_pkg::DIV_STAGES; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < gsd_pkg::DIV_STAGES; k++) begin
        vld[k] <= (k == 0) ? in_vld : vld[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_vld  = vld[gsd_pkg::DIV_STAGES-1];
  assign quot     = quo[gsd_pkg::DIV_STAGES-1];
  assign rem_nz   = |rem[gsd_pkg::DIV_STAGES-1];
  assign side_out = side[gsd_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/core/gsd_interp.sv =====
// Three-stage speed interpolation of the minimum and buffer distance tables.
module gsd_interp (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gsd_pkg::SPD_W-1:0]   ve,
  input  logic                        heavy,
  output logic [gsd_pkg::DIST_W-1:0]  min_dist,
  output logic [gsd_pkg::DIST_W-1:0]  buf_dist
);

  logic [18:0] u;
  logic [15:0] delta_next;
  logic [4:0]  dmin_next, dbuf_next, bmin_next, bbuf_next;
  gsd_pkg::seg_t seg;

  logic [15:0] delta;
  logic [4:0]  dmin, dbuf, bmin, bbuf;
  logic [4:0]  bmin2, bbuf2;
  logic [19:0] xmin, xbuf;
  logic [20:0] pmin_w, pbuf_w;
  logic [40:0] qmin_w, qbuf_w;

  always_comb begin
    u = ({5'b0, ve} << 4) + ({5'b0, ve} << 1);
    if (u <= gsd_pkg::BP_1) begin
      seg = gsd_pkg::SEG_LOW;
    end else if (u >= gsd_pkg::BP_3) begin
      seg = gsd_pkg::SEG_HIGH;
    end else if (u < gsd_pkg::BP_2) begin
      seg = gsd_pkg::SEG_MID0;
    end else begin
      seg = gsd_pkg::SEG_MID1;
    end
    unique case (seg)
      gsd_pkg::SEG_MID0: begin
        delta_next = 16'(u - gsd_pkg::BP_1);
        bmin_next  = gsd_pkg::MIN_TAB[heavy][0];
        bbuf_next  = gsd_pkg::BUF_TAB[heavy][0];
        dmin_next  = gsd_pkg::MIN_TAB[heavy][1] - gsd_pkg::MIN_TAB[heavy][0];
        dbuf_next  = gsd_pkg::BUF_TAB[heavy][1] - gsd_pkg::BUF_TAB[heavy][0];
      end
      gsd_pkg::SEG_MID1: begin
        delta_next = 16'(u - gsd_pkg::BP_2);
        bmin_next  = gsd_pkg::MIN_TAB[heavy][1];
        bbuf_next  = gsd_pkg::BUF_TAB[heavy][1];
        dmin_next  = gsd_pkg::MIN_TAB[heavy][2] - gsd_pkg::MIN_TAB[heavy][1];
        dbuf_next  = gsd_pkg::BUF_TAB[heavy][2] - gsd_pkg::BUF_TAB[heavy][1];
      end
      gsd_pkg::SEG_HIGH: begin
        delta_next = '0;
        bmin_next  = gsd_pkg::MIN_TAB[heavy][2];
        bbuf_next  = gsd_pkg::BUF_TAB[heavy][2];
        dmin_next  = '0;
        dbuf_next  = '0;
      end
      default: begin
        delta_next = '0;
        bmin_next  = gsd_pkg::MIN_TAB[heavy][0];
        bbuf_next  = gsd_pkg::BUF_TAB[heavy][0];
        dmin_next  = '0;
        dbuf_next  = '0;
      end
    endcase
  end

  assign pmin_w = dmin * delta;
  assign pbuf_w = dbuf * delta;
  assign qmin_w = xmin * gsd_pkg::RECIP_200;
  assign qbuf_w = xbuf * gsd_pkg::RECIP_200;

  always_ff @(posedge clk) begin
    if (en) begin
      delta    <= delta_next;
      dmin     <= dmin_next;
      dbuf     <= dbuf_next;
      bmin     <= bmin_next;
      bbuf     <= bbuf_next;
      xmin     <= pmin_w[19:0] + gsd_pkg::ROUND_200;
      xbuf     <= pbuf_w[19:0] + gsd_pkg::ROUND_200;
      bmin2    <= bmin;
      bbuf2    <= bbuf;
      min_dist <= {bmin2, 8'b0} + qmin_w[40:gsd_pkg::RECIP_SH];
      buf_dist <= {bbuf2, 8'b0} + qbuf_w[40:gsd_pkg::RECIP_SH];
    end
  end

endmodule

// ===== rtl/core/gap_safe_distance_calc_top.sv =====
// Top level of the gap safe distance calculator: decode, product, divider, table and clamp.
//
//   channel | signals                                                  | direction
//   in      | in_valid, in_ready, own_speed, object_speed, object_accel,| into block
//           | large_vehicle, object_ahead                              |
//   out     | out_valid, out_ready, safe_distance                      | out of block
//
// One beat is accepted every cycle while in_ready is high; most of the path from a beat to its
// result is the six-stage horizon divider.
// All stages advance together whenever the output register is empty or being drained, so a
// stall on the output holds every stage in place and in_ready falls with it.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
module gap_safe_distance_calc_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gsd_pkg::SPD_W-1:0]         own_speed,
  input  logic [gsd_pkg::SPD_W-1:0]         object_speed,
  input  logic signed [gsd_pkg::ACC_W-1:0]  object_accel,
  input  logic                              large_vehicle,
  input  logic                              object_ahead,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gsd_pkg::OUT_W-1:0]         safe_distance
);

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 0: captured inputs.
  logic                             v0;
  logic [gsd_pkg::SPD_W-1:0]        ve0, vo0;
  logic signed [gsd_pkg::ACC_W-1:0] a0;
  logic                             large0, front0;

  // Stage 1: horizon decision.
  logic                             v1, ratio1;
  logic [gsd_pkg::SPD_W-1:0]        n1, ve1;
  logic signed [16:0]               f1;
  logic [12:0]                      mag1;
  logic                             large1, front1;
  logic signed [gsd_pkg::REL_W-1:0] rel4_1;

  logic signed [14:0]               dv;
  logic [14:0]                      adv;
  logic [12:0]                      mag;
  logic [14:0]                      mag4;
  logic                             a_neg, a_zero, a_pos, dv_neg, dv_zero, mono;
  logic                             ratio_next;
  logic [gsd_pkg::SPD_W-1:0]        n_next;
  logic signed [16:0]               f_next;
  logic signed [gsd_pkg::REL_W-1:0] rel4_next;

  always_comb begin
    dv      = $signed({1'b0, ve0}) - $signed({1'b0, vo0});
    a_neg   = a0[gsd_pkg::ACC_W-1];
    a_zero  = (a0 == '0);
    a_pos   = !a_neg && !a_zero;
    dv_neg  = dv[14];
    dv_zero = (dv == '0);
    mag     = a_neg ? 13'(-a0) : 13'(a0);
    mag4    = {mag, 2'b00};
    adv     = dv_neg ? 15'(-dv) : 15'(dv);
    mono    = (!a_neg && (dv_neg || dv_zero)) || (!a_pos && !dv_neg);
    if (mono) begin
      ratio_next = a_neg && ({1'b0, vo0} < mag4);
      n_next     = vo0;
    end else if ((a_pos && !dv_neg && front0) || (a_neg && dv_neg && !front0)) begin
      ratio_next = adv < mag4;
      n_next     = adv[gsd_pkg::SPD_W-1:0];
    end else begin
      ratio_next = 1'b0;
      n_next     = vo0;
    end
    // The ratio numerator factor is 2*dv + n for negative a and 2*dv - n otherwise.
    if (a_neg) begin
      f_next = $signed({{2{dv[14]}}, dv}) * 17'sd2 + $signed({3'b0, n_next});
    end else begin
      f_next = $signed({{2{dv[14]}}, dv}) * 17'sd2 - $signed({3'b0, n_next});
    end
    rel4_next = $signed({{4{dv[14]}}, dv}) * 19'sd4 - $signed({{6{a0[12]}}, a0}) * 19'sd8;
  end

  // Stage 2: numerator product.
  logic                             v2, ratio2, large2, front2;
  logic signed [31:0]               num2;
  logic [12:0]                      mag2;
  logic [gsd_pkg::SPD_W-1:0]        ve2;
  logic signed [gsd_pkg::REL_W-1:0] rel4_2;

  // Stage 3: rounded numerator split into sign and magnitude.
  logic                             v3;
  logic [gsd_pkg::DIV_NW-1:0]       absn3;
  logic [gsd_pkg::DIV_DW-1:0]       dsr3;
  gsd_pkg::side_t                   side3;

  logic signed [31:0] numr;
  assign numr = num2 + $signed({19'b0, mag2});

  always_ff @(posedge clk) begin
    if (en) begin
      ve0    <= own_speed;
      vo0    <= object_speed;
      a0     <= object_accel;
      large0 <= large_vehicle;
      front0 <= object_ahead;

      ratio1 <= ratio_next;
      n1     <= n_next;
      f1     <= f_next;
      mag1   <= mag;
      ve1    <= ve0;
      large1 <= large0;
      front1 <= front0;
      rel4_1 <= rel4_next;

      num2   <= $signed({1'b0, n1}) * f1;
      mag2   <= mag1;
      ratio2 <= ratio1;
      ve2    <= ve1;
      large2 <= large1;
      front2 <= front1;
      rel4_2 <= rel4_1;

      absn3       <= numr[31] ? gsd_pkg::DIV_NW'(-numr) : gsd_pkg::DIV_NW'(numr);
      dsr3        <= {mag2, 1'b0};
      side3.ratio <= ratio2;
      side3.neg   <= numr[31];
      side3.front <= front2;
      side3.heavy <= large2;
      side3.ve    <= ve2;
      side3.rel4  <= rel4_2;
    end
  end

  // Stages 4 to 9: divider.
  logic                       v9, rnz9;
  logic [gsd_pkg::DIV_QW-1:0] q9;
  gsd_pkg::side_t             side9;

  gsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v3),
    .dividend (absn3),
    .divisor  (dsr3),
    .side_in  (side3),
    .out_vld  (v9),
    .quot     (q9),
    .rem_nz   (rnz9),
    .side_out (side9)
  );

  // Stages 10 to 12: travel term, table lookups in parallel.
  logic [gsd_pkg::DIST_W-1:0]       min12, buf12;

  gsd_interp u_interp (
    .clk      (clk),
    .en       (en),
    .ve       (side9.ve),
    .heavy    (side9.heavy),
    .min_dist (min12),
    .buf_dist (buf12)
  );

  logic signed [gsd_pkg::REL_W-1:0] qext, relr, rel_next;
  logic signed [gsd_pkg::REL_W-1:0] rel10, rel11, rel12;
  logic                             v10, v11, v12;

  always_comb begin
    qext = $signed({1'b0, q9});
    // Floor of a negative quotient steps down when the remainder is not zero.
    relr = side9.neg ? -(qext + $signed({18'b0, rnz9})) : qext;
    rel_next = side9.ratio ? relr : side9.rel4;
    if (!side9.front) begin
      rel_next = -rel_next;
    end
  end

  // Stage 13: buffer, floor at the minimum distance, saturation.
  logic signed [19:0]         total;
  logic signed [19:0]         mind;
  logic [gsd_pkg::OUT_W-1:0]  dist_next;

  always_comb begin
    total = $signed({rel12[18], rel12}) + $signed({7'b0, buf12});
    mind  = $signed({7'b0, min12});
    if (total < mind) begin
      total = mind;
    end
    if (total < 0) begin
      dist_next = '0;
    end else if (total > $signed({3'b0, gsd_pkg::OUT_MAX})) begin
      dist_next = gsd_pkg::OUT_MAX;
    end else begin
      dist_next = total[gsd_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel10         <= rel_next;
      rel11         <= rel10;
      rel12         <= rel11;
      safe_distance <= dist_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v10       <= 1'b0;
      v11       <= 1'b0;
      v12       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      v2        <= v1;
      v3        <= v2;
      v10       <= v9;
      v11       <= v10;
      v12       <= v11;
      out_valid <= v12;
    end
  end

endmodule
